### sv/hsl_pkg.sv
// Shared types and constants for the heightfield slope lightmap core.
package hsl_pkg;

    localparam int HEIGHT_W = 16;
    localparam int GRID_W   = 11;
    localparam int INV_W    = 16;
    localparam int LIGHT_W  = 8;
    localparam int CFG_W    = 16;
    localparam int IDX_W    = 1;

    localparam logic [IDX_W-1:0] CFG_GRID_SIZE   = 1'd0;
    localparam logic [IDX_W-1:0] CFG_INV_SPACING = 1'd1;

    localparam logic [GRID_W-1:0] GRID_SIZE_RESET   = 11'd1025;
    localparam logic [INV_W-1:0]  INV_SPACING_RESET = 16'd256;
    localparam int GRID_MIN = 3;

    localparam int WEIGHT_X   = 16384;
    localparam int WEIGHT_Z   = 9830;
    localparam int FRAC_SHIFT = 25;
    localparam int LIGHT_MAX  = 255;

    localparam int OUT_DEPTH  = 8;

    typedef struct packed {
        logic [HEIGHT_W-1:0] y00;
        logic [HEIGHT_W-1:0] y10;
        logic [HEIGHT_W-1:0] y01;
        logic [HEIGHT_W-1:0] y11;
        logic                row_end;
        logic                frame_end;
    } window_t;

    typedef struct packed {
        logic [LIGHT_W-1:0] light;
        logic               row_end;
        logic               frame_end;
    } result_t;

endpackage

### sv/hsl_fifo.sv
// Small register FIFO used between the front, the back and the result port.
module hsl_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       push,
    input  logic [DW-1:0]              wdata,
    output logic                       full,
    input  logic                       pop,
    output logic [DW-1:0]              rdata,
    output logic                       empty,
    output logic [$clog2(DEPTH+1)-1:0] count
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [DW-1:0] data_reg [DEPTH];
    logic [PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0] count_reg, count_next;
    logic          do_push, do_pop;

    assign full    = (count_reg == CW'(DEPTH));
    assign empty   = (count_reg == '0);
    assign count   = count_reg;
    assign rdata   = data_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            data_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

### sv/hsl_front.sv
// Front end: sample intake, raster counters, line store and window assembly.
module hsl_front
    import hsl_pkg::*;
#(
    parameter int MAX_GRID = 1025
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic [GRID_W-1:0]   grid_size,
    input  logic                push,
    input  logic [HEIGHT_W-1:0] height,
    output logic                full,
    output logic                win_push,
    output window_t             win_data,
    input  logic                win_full
);
    localparam int CW = $clog2(MAX_GRID);
    localparam int NW = $clog2(MAX_GRID + 1);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic                state_reg, state_next;
    logic [CW-1:0]       col_cnt_reg, col_cnt_next;
    logic [CW-1:0]       row_cnt_reg, row_cnt_next;
    logic [CW-1:0]       col_reg, row_reg;
    logic [HEIGHT_W-1:0] h_reg;
    logic [HEIGHT_W-1:0] above_reg;
    logic [HEIGHT_W-1:0] left_reg, left_next;
    logic [HEIGHT_W-1:0] upper_left_reg, upper_left_next;
    logic [HEIGHT_W-1:0] line_mem [MAX_GRID];

    logic [31:0]   size_clamp;
    logic [NW-1:0] n;
    logic [NW-1:0] row_t;
    logic [CW-1:0] col_eff, row_eff;
    logic          accept, produce, done;
    logic [NW-1:0] col_inc, row_inc;

    always_comb
    begin
        size_clamp = 32'(grid_size);
        if (size_clamp < 32'(GRID_MIN))
        begin
            size_clamp = 32'(GRID_MIN);
        end
        if (size_clamp > 32'(MAX_GRID))
        begin
            size_clamp = 32'(MAX_GRID);
        end
        n = size_clamp[NW-1:0];
    end

    always_comb
    begin
        col_eff = col_cnt_reg;
        row_t   = NW'(row_cnt_reg);
        if (NW'(col_cnt_reg) >= n)
        begin
            col_eff = '0;
            row_t   = NW'(row_cnt_reg) + 1'b1;
        end
        row_eff = (row_t >= n) ? '0 : row_t[CW-1:0];
    end

    assign full     = (state_reg != ST_IDLE);
    assign accept   = push && (state_reg == ST_IDLE);
    assign produce  = (col_reg != '0) && (row_reg != '0);
    assign done     = !produce || !win_full;
    assign win_push = (state_reg == ST_EXEC) && produce && !win_full;
    assign col_inc  = NW'(col_reg) + 1'b1;
    assign row_inc  = NW'(row_reg) + 1'b1;

    always_comb
    begin
        win_data.y00       = upper_left_reg;
        win_data.y10       = above_reg;
        win_data.y01       = left_reg;
        win_data.y11       = h_reg;
        win_data.row_end   = (col_inc == n);
        win_data.frame_end = (col_inc == n) && (row_inc == n);
    end

    always_comb
    begin
        state_next      = state_reg;
        col_cnt_next    = col_cnt_reg;
        row_cnt_next    = row_cnt_reg;
        left_next       = left_reg;
        upper_left_next = upper_left_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (done)
                begin
                    state_next      = ST_IDLE;
                    left_next       = h_reg;
                    upper_left_next = above_reg;
                    if (col_inc >= n)
                    begin
                        col_cnt_next = '0;
                        row_cnt_next = (row_inc >= n) ? '0 : row_inc[CW-1:0];
                    end
                    else
                    begin
                        col_cnt_next = col_inc[CW-1:0];
                        row_cnt_next = row_reg;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            col_cnt_reg    <= '0;
            row_cnt_reg    <= '0;
            left_reg       <= '0;
            upper_left_reg <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            col_cnt_reg    <= col_cnt_next;
            row_cnt_reg    <= row_cnt_next;
            left_reg       <= left_next;
            upper_left_reg <= upper_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            h_reg     <= height;
            col_reg   <= col_eff;
            row_reg   <= row_eff;
            above_reg <= line_mem[col_eff];
        end
        if ((state_reg == ST_EXEC) && done)
        begin
            line_mem[col_reg] <= h_reg;
        end
    end

endmodule

### sv/hsl_back.sv
// Back end: slope shading pipeline with a credit-guarded result queue.
module hsl_back
    import hsl_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic [INV_W-1:0] inv_spacing,
    input  logic             win_empty,
    input  window_t          win_data,
    output logic             win_pop,
    input  logic             pop,
    output logic             empty,
    output result_t          result
);
    localparam int STAGES = 5;
    localparam int OCW    = $clog2(OUT_DEPTH + 1);
    localparam int SW     = ((OCW > 3) ? OCW : 3) + 1;
    localparam int DW     = 19;
    localparam int WW     = 34;
    localparam int PWID   = WW + INV_W + 1;
    localparam int UW     = PWID + 1;
    localparam int TW     = UW + 9;
    localparam int QW     = TW - FRAC_SHIFT;

    localparam logic signed [WW-1:0] WX   = WW'(WEIGHT_X);
    localparam logic signed [WW-1:0] WZ   = WW'(WEIGHT_Z);
    localparam logic signed [UW-1:0] HALF = UW'(1) <<< (FRAC_SHIFT - 1);
    localparam logic signed [QW-1:0] QMAX = QW'(LIGHT_MAX);

    logic [STAGES-1:0] vld_reg;
    logic [1:0]        flg_reg [STAGES];

    logic signed [DW-1:0]   dx_reg, dz_reg;
    logic signed [WW-1:0]   w_reg;
    logic signed [PWID-1:0] s_reg;
    logic signed [UW-1:0]   u_reg;
    logic signed [TW-1:0]   t_reg;

    logic signed [DW-1:0] y00, y10, y01, y11;
    logic signed [TW-1:0] u_ext;
    logic signed [QW-1:0] q;
    logic [LIGHT_W-1:0]   light;
    logic [OCW-1:0]       out_count;
    logic [SW-1:0]        pending;
    result_t              res_in;

    assign pending = SW'(out_count) + SW'($countones(vld_reg));
    assign win_pop = !win_empty && (pending < SW'(OUT_DEPTH));

    assign y00   = $signed(DW'(win_data.y00));
    assign y10   = $signed(DW'(win_data.y10));
    assign y01   = $signed(DW'(win_data.y01));
    assign y11   = $signed(DW'(win_data.y11));
    assign u_ext = TW'(u_reg);
    assign q     = QW'(t_reg >>> FRAC_SHIFT);

    always_comb
    begin
        if (t_reg <= 0)
        begin
            light = '0;
        end
        else if (q > QMAX)
        begin
            light = LIGHT_W'(LIGHT_MAX);
        end
        else
        begin
            light = q[LIGHT_W-1:0];
        end
        res_in.light     = light;
        res_in.row_end   = flg_reg[STAGES-1][1];
        res_in.frame_end = flg_reg[STAGES-1][0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= {vld_reg[STAGES-2:0], win_pop};
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= (y00 - y10) + (y01 - y11);
        dz_reg     <= (y00 - y01) + (y10 - y11);
        flg_reg[0] <= {win_data.row_end, win_data.frame_end};
        w_reg      <= WW'(dx_reg) * WX + WW'(dz_reg) * WZ;
        s_reg      <= PWID'(w_reg) * $signed(PWID'(inv_spacing));
        u_reg      <= UW'(s_reg) + HALF;
        t_reg      <= (u_ext <<< 8) - u_ext;
        for (int i = 1; i < STAGES; i++)
        begin
            flg_reg[i] <= flg_reg[i-1];
        end
    end

    hsl_fifo #(
        .DW    ($bits(result_t)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (vld_reg[STAGES-1]),
        .wdata (res_in),
        .full  (),
        .pop   (pop),
        .rdata (result),
        .empty (empty),
        .count (out_count)
    );

endmodule

### sv/heightfield_slope_lightmap_core.sv
// Top level of the heightfield slope lightmap core.
// Height samples enter one beat at a time in raster order. The front end reads the line store
// entry above each sample into a register, then writes the new sample into that same entry and
// takes no new sample until that write, which a full window queue can hold back. Shading runs
// in a five-stage pipeline behind a four-entry window queue, and results wait in an
// eight-entry queue, so a stalled consumer holds back intake only once both queues fill.
// The line store holds MAX_GRID entries and needs no clearing after reset. The user must write
// configuration through cfg_we, cfg_index and cfg_data while idle; the core does not check it.
module heightfield_slope_lightmap_core
    import hsl_pkg::*;
#(
    parameter int MAX_GRID = 1025
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [IDX_W-1:0]    cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic                push,
    input  logic [HEIGHT_W-1:0] height,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output logic [LIGHT_W-1:0]  light,
    output logic                row_end,
    output logic                frame_end
);
    localparam int WIN_DEPTH = 4;

    logic [GRID_W-1:0] grid_size_reg;
    logic [INV_W-1:0]  inv_spacing_reg;

    logic    win_push, win_full, win_pop, win_empty;
    window_t win_in, win_out;
    result_t result;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg   <= GRID_SIZE_RESET;
            inv_spacing_reg <= INV_SPACING_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_GRID_SIZE:   grid_size_reg   <= cfg_data[GRID_W-1:0];
                CFG_INV_SPACING: inv_spacing_reg <= cfg_data[INV_W-1:0];
                default:         grid_size_reg   <= grid_size_reg;
            endcase
        end
    end

    hsl_front #(
        .MAX_GRID (MAX_GRID)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .grid_size (grid_size_reg),
        .push      (push),
        .height    (height),
        .full      (full),
        .win_push  (win_push),
        .win_data  (win_in),
        .win_full  (win_full)
    );

    hsl_fifo #(
        .DW    ($bits(window_t)),
        .DEPTH (WIN_DEPTH)
    ) u_win_fifo (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (win_push),
        .wdata (win_in),
        .full  (win_full),
        .pop   (win_pop),
        .rdata (win_out),
        .empty (win_empty),
        .count ()
    );

    hsl_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .inv_spacing (inv_spacing_reg),
        .win_empty   (win_empty),
        .win_data    (win_out),
        .win_pop     (win_pop),
        .pop         (pop),
        .empty       (empty),
        .result      (result)
    );

    assign light     = result.light;
    assign row_end   = result.row_end;
    assign frame_end = result.frame_end;

endmodule

### sv/hsl_checker.sv
// Port-level checks for the heightfield slope lightmap core, bound to the top level.
module hsl_checker
    import hsl_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               push,
    input logic               full,
    input logic               pop,
    input logic               empty,
    input logic [LIGHT_W-1:0] light,
    input logic               row_end,
    input logic               frame_end
);

    a_frame_end_closes_row: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (!frame_end || row_end))
        else $error("frame end without row end");

    a_intake_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("new beat taken before previous sample finished");

    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(light) && $stable(row_end)
                              && $stable(frame_end)))
        else $error("waiting result changed");

endmodule

bind heightfield_slope_lightmap_core hsl_checker u_hsl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .full      (full),
    .pop       (pop),
    .empty     (empty),
    .light     (light),
    .row_end   (row_end),
    .frame_end (frame_end)
);

### bench/heightfield_slope_lightmap_core_test.sv
// Self-checking testbench for the heightfield slope lightmap core with a built-in shading predictor.
`timescale 1ns / 100ps

module heightfield_slope_lightmap_core_test;
    import hsl_pkg::*;

    localparam int GRID_LIMIT   = 1025;
    localparam int RANDOM_ITEMS = 300;
    localparam int QUIET_CYCLES = 60;
    localparam int DRAIN_LIMIT  = 20000;
    localparam int REPORT_LIMIT = 10;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_data = '0;
    logic                push = 1'b0;
    logic [HEIGHT_W-1:0] height = '0;
    logic                pop = 1'b0;
    logic                full;
    logic                empty;
    logic [LIGHT_W-1:0]  light;
    logic                row_end;
    logic                frame_end;

    heightfield_slope_lightmap_core #(
        .MAX_GRID (GRID_LIMIT)
    ) u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .height    (height),
        .full      (full),
        .pop       (pop),
        .empty     (empty),
        .light     (light),
        .row_end   (row_end),
        .frame_end (frame_end)
    );

    // predictor state
    logic [GRID_W-1:0]   grid_word = GRID_SIZE_RESET;
    logic [INV_W-1:0]    spacing_word = INV_SPACING_RESET;
    logic [HEIGHT_W-1:0] line_mem [GRID_LIMIT];
    logic [HEIGHT_W-1:0] left_h = '0;
    logic [HEIGHT_W-1:0] upper_left_h = '0;
    int                  col_pos = 0;
    int                  row_pos = 0;

    logic [HEIGHT_W-1:0] sample_q [$];
    result_t             lightmap_q [$];
    int                  fault_count = 0;
    bit                  calm = 1'b0;
    logic                in_taken = 1'b0;
    logic                out_taken = 1'b0;
    int                  in_gap = 0;
    int                  out_wait = 0;

    initial
    begin
        forever #5 clk = ~clk;
    end

    initial
    begin
        #3_000_000;
        $display("Regression FAIL");
        $finish;
    end

    function automatic int draw_gap();
        return calm ? 0 : int'($urandom_range(0, 3));
    endfunction

    function automatic logic [LIGHT_W-1:0] shade_window(
        input logic [HEIGHT_W-1:0] y00,
        input logic [HEIGHT_W-1:0] y10,
        input logic [HEIGHT_W-1:0] y01,
        input logic [HEIGHT_W-1:0] y11
    );
        longint a, b, c, d, inv, dx, dz, s, t, q;
        a = longint'(y00);
        b = longint'(y10);
        c = longint'(y01);
        d = longint'(y11);
        inv = longint'(spacing_word);
        dx = (a - b) + (c - d);
        dz = (a - c) + (b - d);
        s = (dx * WEIGHT_X + dz * WEIGHT_Z) * inv;
        t = (s + (longint'(1) << (FRAC_SHIFT - 1))) * LIGHT_MAX;
        if (t <= 0)
            return '0;
        q = t >>> FRAC_SHIFT;
        if (q > LIGHT_MAX)
            q = longint'(LIGHT_MAX);
        return q[LIGHT_W-1:0];
    endfunction

    function automatic void advance_grid(input logic [HEIGHT_W-1:0] h);
        int n;
        logic [HEIGHT_W-1:0] above;
        result_t r;
        n = int'(grid_word);
        if (n < GRID_MIN)
            n = GRID_MIN;
        if (n > GRID_LIMIT)
            n = GRID_LIMIT;
        if (col_pos >= n)
        begin
            col_pos = 0;
            row_pos = row_pos + 1;
        end
        if (row_pos >= n)
            row_pos = 0;
        above = line_mem[col_pos];
        if (col_pos >= 1 && row_pos >= 1)
        begin
            r.light     = shade_window(upper_left_h, above, left_h, h);
            r.row_end   = (col_pos == n - 1);
            r.frame_end = (col_pos == n - 1) && (row_pos == n - 1);
            lightmap_q.push_back(r);
        end
        upper_left_h = above;
        line_mem[col_pos] = h;
        left_h = h;
        if (col_pos + 1 >= n)
        begin
            col_pos = 0;
            row_pos = (row_pos + 1 >= n) ? 0 : row_pos + 1;
        end
        else
        begin
            col_pos = col_pos + 1;
        end
    endfunction

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT)
            $display("%0t: %s", $time, msg);
    endtask

    // monitor: track config, predict on each input beat, check each result beat
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n)
        begin
            in_taken  <= push && !full;
            out_taken <= pop && !empty;
            if (cfg_we)
            begin
                if (cfg_index == CFG_GRID_SIZE)
                    grid_word = cfg_data[GRID_W-1:0];
                else if (cfg_index == CFG_INV_SPACING)
                    spacing_word = cfg_data[INV_W-1:0];
            end
            if (push && !full)
                advance_grid(height);
            if (pop && !empty)
            begin
                if (lightmap_q.size() == 0)
                begin
                    note_fault($sformatf("unexpected result light %0d row_end %0b frame_end %0b",
                        light, row_end, frame_end));
                end
                else
                begin
                    want = lightmap_q.pop_front();
                    if (light !== want.light || row_end !== want.row_end
                        || frame_end !== want.frame_end)
                        note_fault($sformatf(
                            "mismatch light %0d/%0d row_end %0b/%0b frame_end %0b/%0b (exp/got)",
                            want.light, light, want.row_end, row_end,
                            want.frame_end, frame_end));
                end
            end
        end
    end

    // input driver: hold until the beat is taken, then idle or advance
    always @(negedge clk)
    begin
        if (rst_n && !(push && !in_taken))
        begin
            if (in_gap != 0)
            begin
                push   <= 1'b0;
                in_gap <= in_gap - 1;
            end
            else if (sample_q.size() != 0)
            begin
                push   <= 1'b1;
                height <= sample_q.pop_front();
                in_gap <= draw_gap();
            end
            else
            begin
                push <= 1'b0;
            end
        end
    end

    // result side: after each beat, stall for a random gap from draw_gap (none when calm)
    always @(negedge clk)
    begin
        int w;
        if (rst_n)
        begin
            if (out_taken)
            begin
                w = draw_gap();
                out_wait <= w;
                pop      <= (w == 0);
            end
            else if (out_wait != 0)
            begin
                out_wait <= out_wait - 1;
                pop      <= (out_wait == 1);
            end
            else
            begin
                pop <= 1'b1;
            end
        end
    end

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic settle();
        int spins;
        spins = 0;
        @(posedge clk);
        #1;
        while ((sample_q.size() != 0 || push || lightmap_q.size() != 0) && spins < DRAIN_LIMIT)
        begin
            @(posedge clk);
            #1;
            spins++;
        end
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic write_grid(input int g);
        logic [CFG_W-1:0] data;
        data = CFG_W'($urandom_range(0, 65535));
        data[GRID_W-1:0] = GRID_W'(g);
        write_reg(CFG_GRID_SIZE, data);
    endtask

    task automatic queue_samples(input int count, input int style);
        int k;
        int base;
        logic [HEIGHT_W-1:0] h;
        base = int'($urandom_range(0, 65535));
        for (k = 0; k < count; k++)
        begin
            case (style)
                0: h = HEIGHT_W'($urandom_range(0, 65535));
                1: h = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                default:
                begin
                    base = base + int'($urandom_range(0, 4)) - 2;
                    h = HEIGHT_W'(base);
                end
            endcase
            sample_q.push_back(h);
        end
    endtask

    task automatic queue_list(input logic [HEIGHT_W-1:0] v [9]);
        int k;
        for (k = 0; k < 9; k++)
            sample_q.push_back(v[k]);
    endtask

    initial
    begin
        int sent;
        int len;
        logic [INV_W-1:0] inv;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // directed: smallest grid, saturation both ways
        write_grid(0);
        queue_list('{16'hFFFF, 16'h0000, 16'hFFFF,
                     16'h0000, 16'hFFFF, 16'h0000,
                     16'hFFFF, 16'hFFFF, 16'h0000});
        settle();
        write_reg(CFG_INV_SPACING, 16'h0000);
        queue_samples(9, 0);
        settle();
        write_grid(2);
        write_reg(CFG_INV_SPACING, 16'hFFFF);
        queue_list('{16'h0000, 16'h0000, 16'h0001,
                     16'h0000, 16'h0000, 16'h0000,
                     16'h0001, 16'h0000, 16'h0000});
        settle();

        // widest grid: fill the line store, then a few cells of the second row
        write_grid(GRID_LIMIT);
        write_reg(CFG_INV_SPACING, 16'($urandom_range(1, 64)));
        queue_samples(GRID_LIMIT + 8, 2);
        settle();
        write_reg(CFG_GRID_SIZE, 16'hFFFF);

        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if ($urandom_range(0, 2) != 0)
            begin
                settle();
                if ($urandom_range(0, 1))
                begin
                    case ($urandom_range(0, 9))
                        0: write_grid($urandom_range(0, GRID_MIN - 1));
                        1: write_grid($urandom_range(GRID_LIMIT, 2047));
                        default: write_grid($urandom_range(GRID_MIN, 9));
                    endcase
                end
                if ($urandom_range(0, 1))
                begin
                    case ($urandom_range(0, 5))
                        0: inv = '0;
                        1: inv = 16'hFFFF;
                        2: inv = 16'd1;
                        3: inv = INV_SPACING_RESET;
                        4: inv = INV_W'($urandom_range(1, 64));
                        default: inv = INV_W'($urandom_range(0, 65535));
                    endcase
                    write_reg(CFG_INV_SPACING, inv);
                end
            end
            calm = ($urandom_range(0, 3) == 0);
            len = $urandom_range(8, 60);
            queue_samples(len, $urandom_range(0, 3));
            sent += len;
        end

        settle();
        if (lightmap_q.size() != 0)
            note_fault($sformatf("%0d expected results never arrived", lightmap_q.size()));
        if (fault_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
